// ----- src/bpa_pkg.sv -----
// Shared types and constants for the bitmap page allocator.
// Depends on nothing; imported by bitmap_page_allocator_core and its testbench.
package bpa_pkg;

    localparam logic [31:0] REGION_BASE = 32'h2000_0000;
    localparam int          PAGE_SHIFT  = 12;
    localparam logic [31:0] PAGE_ROUND  = 32'h0000_0FFF;
    localparam int          WORD_BITS   = 32;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_NONE_FREE    = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CLEAR     = 8'b0000_0010,
        ST_INIT_PREP = 8'b0000_0100,
        ST_INIT_FILL = 8'b0000_1000,
        ST_ALLOC     = 8'b0001_0000,
        ST_FREE_RD   = 8'b0010_0000,
        ST_FREE_WR   = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } bpa_state_t;

endpackage

// ----- src/bitmap_page_allocator_core.sv -----
// Bitmap free-page allocator core with a one-word-per-cycle map sequencer.
// Depends on bpa_pkg for op codes, status codes and state encoding.
// Init sizes the reserved area then fills the map, allocate scans for a free page, free reads
// then rewrites a word. The next item is accepted from the cycle its result appears.
// After reset the map is swept word by word to all free before in_ready rises.
// Reset is asynchronous and active low; the reserved end register resets to the region base.
module bitmap_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int PAGES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] page_address,
    output logic [1:0]  status
);

    localparam int MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WORD_CW   = $clog2(MAP_WORDS + 1);
    localparam int PAGE_CW   = $clog2(PAGES + 1);
    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(MAP_WORDS - 1);
    localparam logic [WORD_CW-1:0] WORD_COUNT = WORD_CW'(MAP_WORDS);
    localparam logic [31:0]        PAGES_W    = 32'(PAGES);

    function automatic logic [31:0] low_ones(input logic [5:0] n);
        logic [31:0] r;
        if (n >= 6'd32)
        begin
            r = '1;
        end
        else
        begin
            r = (32'd1 << n) - 32'd1;
        end
        return r;
    endfunction

    function automatic logic [5:0] clamp32(input logic [31:0] v);
        logic [5:0] r;
        if (v >= 32'd32)
        begin
            r = 6'd32;
        end
        else
        begin
            r = v[5:0];
        end
        return r;
    endfunction

    bpa_state_t state_reg, state_next;
    logic [31:0]        reserved_end_reg;
    logic [WORD_AW-1:0] fill_cnt_reg, fill_cnt_next;
    logic [PAGE_CW-1:0] used_reg, used_next;
    logic [WORD_CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [WORD_AW-1:0] chk_word_reg, chk_word_next;
    logic [WORD_AW-1:0] free_word_reg, free_word_next;
    logic [4:0]         free_bit_reg, free_bit_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        page_address_reg, page_address_next;
    logic [1:0]         status_reg, status_next;

    logic [31:0]        map_mem [MAP_WORDS];
    logic [31:0]        rdata_reg;
    logic [WORD_AW-1:0] mem_raddr;
    logic               mem_we;
    logic [WORD_AW-1:0] mem_waddr;
    logic [31:0]        mem_wdata;

    logic [31:0] first_page;
    logic [31:0] used_page;
    logic [5:0]  lo_cnt;
    logic [5:0]  hi_cnt;
    logic [31:0] fill_word;
    logic [4:0]  low_bit;
    logic [16:0] req_page;
    logic [32:0] round_up;
    logic [32:0] used_raw;
    logic        issue;
    logic        found;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_raddr];
    end

    always_comb
    begin
        first_page = 32'({fill_cnt_reg, 5'd0});
        used_page  = (state_reg == ST_CLEAR) ? 32'd0 : 32'(used_reg);
        if (used_page > first_page)
        begin
            lo_cnt = clamp32(used_page - first_page);
        end
        else
        begin
            lo_cnt = 6'd0;
        end
        hi_cnt    = clamp32(PAGES_W - first_page);
        fill_word = low_ones(hi_cnt) & ~low_ones(lo_cnt);
    end

    always_comb
    begin
        low_bit = 5'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (rdata_reg[i])
            begin
                low_bit = 5'(i);
            end
        end
    end

    always_comb
    begin
        if (reserved_end_reg > REGION_BASE)
        begin
            round_up = {1'b0, reserved_end_reg} - {1'b0, REGION_BASE} + {1'b0, PAGE_ROUND};
        end
        else
        begin
            round_up = 33'd0;
        end
        used_raw = round_up >> PAGE_SHIFT;
    end

    assign req_page  = free_address[28:12];
    assign issue     = (state_reg == ST_ALLOC) && (issue_cnt_reg < WORD_COUNT);
    assign found     = (state_reg == ST_ALLOC) && chk_valid_reg && (rdata_reg != 32'd0);
    assign mem_raddr = (state_reg == ST_FREE_RD) ? free_word_reg
                                                 : issue_cnt_reg[WORD_AW-1:0];

    always_comb
    begin
        state_next        = state_reg;
        fill_cnt_next     = fill_cnt_reg;
        used_next         = used_reg;
        issue_cnt_next    = issue_cnt_reg;
        chk_valid_next    = 1'b0;
        chk_word_next     = chk_word_reg;
        free_word_next    = free_word_reg;
        free_bit_next     = free_bit_reg;
        res_addr_next     = res_addr_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        page_address_next = page_address_reg;
        status_next       = status_reg;
        mem_we            = 1'b0;
        mem_waddr         = fill_cnt_reg;
        mem_wdata         = fill_word;
        in_ready          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                res_addr_next   = 32'd0;
                res_status_next = STATUS_OK;
                if (in_valid)
                begin
                    unique case (op)
                        OP_INIT:
                        begin
                            state_next = ST_INIT_PREP;
                        end
                        OP_ALLOC:
                        begin
                            issue_cnt_next = '0;
                            state_next     = ST_ALLOC;
                        end
                        OP_FREE:
                        begin
                            if (32'(req_page) >= PAGES_W)
                            begin
                                res_status_next = STATUS_OUT_OF_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                free_word_next = WORD_AW'(req_page >> 5);
                                free_bit_next  = req_page[4:0];
                                state_next     = ST_FREE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR, ST_INIT_FILL:
            begin
                mem_we = 1'b1;
                if (fill_cnt_reg == LAST_WORD)
                begin
                    fill_cnt_next = '0;
                    state_next    = (state_reg == ST_CLEAR) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            ST_INIT_PREP:
            begin
                if (used_raw >= 33'(PAGES))
                begin
                    used_next = PAGE_CW'(PAGES);
                end
                else
                begin
                    used_next = PAGE_CW'(used_raw);
                end
                fill_cnt_next = '0;
                state_next    = ST_INIT_FILL;
            end
            ST_ALLOC:
            begin
                chk_valid_next = issue;
                chk_word_next  = issue_cnt_reg[WORD_AW-1:0];
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (found)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_word_reg;
                    mem_wdata       = rdata_reg & ~(32'd1 << low_bit);
                    res_addr_next   = REGION_BASE
                                    + (32'({chk_word_reg, low_bit}) << PAGE_SHIFT);
                    res_status_next = STATUS_OK;
                    chk_valid_next  = 1'b0;
                    state_next      = ST_DONE;
                end
                else if (chk_valid_reg && (chk_word_reg == LAST_WORD))
                begin
                    res_status_next = STATUS_NONE_FREE;
                    chk_valid_next  = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = free_word_reg;
                mem_wdata  = rdata_reg | (32'd1 << free_bit_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    page_address_next = res_addr_reg;
                    status_next       = res_status_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            reserved_end_reg <= REGION_BASE;
            fill_cnt_reg     <= '0;
            issue_cnt_reg    <= '0;
            chk_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                reserved_end_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg         <= used_next;
        chk_word_reg     <= chk_word_next;
        free_word_reg    <= free_word_next;
        free_bit_reg     <= free_bit_next;
        res_addr_reg     <= res_addr_next;
        res_status_reg   <= res_status_next;
        page_address_reg <= page_address_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_INIT_FILL
                    || state_reg == ST_ALLOC || state_reg == ST_FREE_WR))
        else $error("map written outside a writing state");

    a_check_in_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_ALLOC))
        else $error("pending map read outside an allocation scan");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        found |=> (state_reg == ST_DONE && res_status_reg == STATUS_OK
                   && res_addr_reg >= REGION_BASE))
        else $error("allocation hit did not produce an ok result");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result item appeared without completing an operation");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == STATUS_OK || status_reg == STATUS_NONE_FREE
                           || status_reg == STATUS_OUT_OF_RANGE))
        else $error("result item carries an undefined status");
`endif

endmodule

// ----- tb/bitmap_page_allocator_core_tb.sv -----
// Self-checking testbench for bitmap_page_allocator_core: a shadow free-page map predicts
// every result of init, allocate and free, and each result is compared as it leaves.
// Depends on bpa_pkg and bitmap_page_allocator_core.
module bitmap_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int PAGES = 1024;
    localparam int MAP_WORDS = (PAGES + 31) / 32;
    localparam int SETTLE_CYCLES = MAP_WORDS + 8;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [31:0] page_address;
        logic [1:0]  status;
    } map_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] free_address;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] page_address;
    logic [1:0]  status;

    logic [31:0] shadow_free_map [MAP_WORDS];
    logic [31:0] reserved_end;
    map_result_t pending_results [$];
    int          granted_pages [$];

    bit idle_on = 1'b1;
    int sink_hold = 0;
    int items_sent = 0;
    int results_seen = 0;
    int refused_allocs = 0;
    int rejected_frees = 0;
    int reserved_writes = 0;
    int mismatch_count = 0;

    bitmap_page_allocator_core #(.PAGES(PAGES)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .page_address (page_address),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("bitmap_page_allocator_core test failed");
        $finish;
    end

    function automatic void mark_map_free();
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            shadow_free_map[w] = (PAGES - w * 32 >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'd1 << (PAGES - w * 32)) - 32'd1);
        end
    endfunction

    function automatic map_result_t apply_map_op(logic [1:0] opc, logic [31:0] addr);
        map_result_t r;
        longint unsigned used;
        int page;
        bit found;
        r.page_address = '0;
        r.status = STATUS_OK;
        case (opc)
            OP_INIT:
            begin
                mark_map_free();
                used = 0;
                if (reserved_end > REGION_BASE)
                    used = ({32'd0, reserved_end - REGION_BASE} + 64'd4095) >> PAGE_SHIFT;
                if (used > PAGES)
                    used = PAGES;
                for (int p = 0; p < int'(used); p++)
                    shadow_free_map[p / 32][p % 32] = 1'b0;
            end
            OP_ALLOC:
            begin
                found = 1'b0;
                for (int w = 0; w < MAP_WORDS && !found; w++)
                begin
                    for (int b = 0; b < 32 && !found; b++)
                    begin
                        if (shadow_free_map[w][b])
                        begin
                            shadow_free_map[w][b] = 1'b0;
                            r.page_address = REGION_BASE + 32'((w * 32 + b) << PAGE_SHIFT);
                            granted_pages.push_back(w * 32 + b);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    r.status = STATUS_NONE_FREE;
            end
            OP_FREE:
            begin
                page = int'((addr & (REGION_BASE - 32'd1)) >> PAGE_SHIFT);
                if (page >= PAGES)
                    r.status = STATUS_OUT_OF_RANGE;
                else
                    shadow_free_map[page / 32][page % 32] = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Result side: random stalls, plus a long hold counted down here when requested.
    initial
    begin : result_sink
        int gap_left;
        gap_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                out_ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                gap_left = $urandom_range(0, 15);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual page_address %h status %0d",
                         $time, page_address, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (page_address !== want.page_address)
                begin
                    $display("%0t: page_address expected %h actual %h",
                             $time, want.page_address, page_address);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    mismatch_count++;
                end
                if (want.status == STATUS_NONE_FREE)
                    refused_allocs++;
                if (want.status == STATUS_OUT_OF_RANGE)
                    rejected_frees++;
            end
        end
    end

    task automatic send_item(input logic [1:0] opc, input logic [31:0] addr);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= opc;
        free_address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_map_op(opc, addr));
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reserved(input logic [31:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        reserved_end = value;
        reserved_writes++;
    endtask

    function automatic logic [31:0] pick_free_address();
        logic [16:0] page;
        int k;
        if (granted_pages.size() > 0 && $urandom_range(0, 1) == 1)
        begin
            k = $urandom_range(0, granted_pages.size() - 1);
            page = 17'(granted_pages[k]);
            granted_pages.delete(k);
        end
        else if ($urandom_range(0, 9) == 0)
            page = 17'($urandom);
        else
            page = 17'($urandom_range(0, PAGES - 1));
        return {3'($urandom_range(0, 7)), page, 12'($urandom)};
    endfunction

    function automatic logic [31:0] pick_reserved_end();
        case ($urandom_range(0, 5))
            0: return REGION_BASE + 32'($urandom_range(0, PAGES << PAGE_SHIFT));
            1: return $urandom;
            2: return 32'($urandom_range(0, REGION_BASE));
            default: return REGION_BASE + 32'($urandom_range(PAGES - 48, PAGES) << PAGE_SHIFT)
                            - 32'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            send_item(OP_ALLOC, $urandom);
        else if (roll < 88)
            send_item(OP_FREE, pick_free_address());
        else if (roll < 94)
            send_item(OP_INIT, $urandom);
        else
            send_item(OP_NOP, $urandom);
    endtask

    task automatic test_ops_after_reset();
        send_item(OP_NOP, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'h0);
        send_item(OP_ALLOC, 32'hFFFF_FFFF);
        send_item(OP_FREE, 32'h2000_0000);
        send_item(OP_FREE, 32'h2000_0FFF);
        send_item(OP_FREE, 32'hE000_1000);
        send_item(OP_FREE, 32'h003F_FFFF);
        send_item(OP_FREE, 32'h0040_0000);
        send_item(OP_FREE, 32'hFFFF_FFFF);
        send_item(OP_FREE, 32'h0000_0000);
        send_item(OP_ALLOC, 32'h0);
    endtask

    task automatic test_reserved_extremes();
        set_reserved(32'h0000_0000);
        send_item(OP_INIT, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'h0);
        set_reserved(REGION_BASE + 32'd1);
        send_item(OP_INIT, 32'h0);
        send_item(OP_ALLOC, 32'h0);
        set_reserved(REGION_BASE + 32'((PAGES - 1) << PAGE_SHIFT));
        send_item(OP_INIT, 32'h0);
        send_item(OP_ALLOC, 32'h0);
        send_item(OP_ALLOC, 32'h0);
        set_reserved(32'hFFFF_FFFF);
        send_item(OP_INIT, 32'h0);
        send_item(OP_ALLOC, 32'h0);
        send_item(OP_FREE, REGION_BASE + 32'h0000_5000);
        send_item(OP_ALLOC, 32'h0);
        set_reserved(REGION_BASE);
        send_item(OP_INIT, 32'h0);
        send_item(OP_ALLOC, 32'h0);
    endtask

    task automatic test_output_stall();
        wait_for_results();
        sink_hold = 300;
        repeat (12) send_random_item();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            set_reserved(pick_reserved_end());
            if (phase == 7)
                idle_on = 1'b0;
            send_item(OP_INIT, $urandom);
            repeat (47) send_random_item();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        op = OP_NOP;
        free_address = '0;
        reserved_end = REGION_BASE;
        mark_map_free();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ops_after_reset();
        test_reserved_extremes();
        test_output_stall();
        test_random_phases();
        wait_for_results();

        $display("Sent %0d items over %0d reserved-end settings and checked %0d results.",
                 items_sent, reserved_writes, results_seen);
        $display("Allocations refused on a full map: %0d, frees out of range: %0d.",
                 refused_allocs, rejected_frees);
        if (mismatch_count == 0)
            $display("bitmap_page_allocator_core test passed");
        else
            $display("bitmap_page_allocator_core test failed");
        $finish;
    end

endmodule

// ----- bitmap_page_allocator_core.f -----
src/bpa_pkg.sv
src/bitmap_page_allocator_core.sv
tb/bitmap_page_allocator_core_tb.sv
